[design/cot_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cot_pkg: shared types, constants and microcode for the capsule overlap test
// Register file map, flag map and the sequencer program that computes the
// closest-points overlap test one scalar operation at a time.
// ----------------------------------------------------------------------------
package cot_pkg;

  // field widths fixed by the interface
  localparam int COORD_BITS_DEF = 24;
  localparam int RADIUS_BITS    = 23;
  localparam int INDEX_BITS     = 8;
  localparam int CFG_IDX_BITS   = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_OWN_RADIUS = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEAD_INDEX = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TAIL_INDEX = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_X   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_Y   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_Z   = 3'd5;

  // operation codes of an input word
  localparam logic OPER_UPDATE = 1'b0;
  localparam logic OPER_TEST   = 1'b1;

  // register file
  localparam int RF_AW    = 6;
  localparam int RF_DEPTH = 64;
  typedef logic [RF_AW-1:0] raddr_t;

  localparam raddr_t RA_Z   = 6'd0;   // constant zero
  localparam raddr_t RA_P   = 6'd1;   // stored start point x,y,z
  localparam raddr_t RA_Q   = 6'd4;   // stored end point x,y,z
  localparam raddr_t RA_S2  = 6'd7;   // other segment start
  localparam raddr_t RA_E2  = 6'd10;  // other segment end
  localparam raddr_t RA_RS  = 6'd13;  // radius sum
  localparam raddr_t RA_R2  = 6'd14;  // squared radius sum
  localparam raddr_t RA_W   = 6'd15;
  localparam raddr_t RA_D   = 6'd18;
  localparam raddr_t RA_V   = 6'd21;
  localparam raddr_t RA_WD  = 6'd24;
  localparam raddr_t RA_DD  = 6'd25;
  localparam raddr_t RA_WW  = 6'd26;
  localparam raddr_t RA_VV  = 6'd27;
  localparam raddr_t RA_T0  = 6'd28;
  localparam raddr_t RA_T1  = 6'd29;
  localparam raddr_t RA_D1  = 6'd30;
  localparam raddr_t RA_D2  = 6'd33;
  localparam raddr_t RA_RR  = 6'd36;
  localparam raddr_t RA_A   = 6'd39;
  localparam raddr_t RA_B   = 6'd40;
  localparam raddr_t RA_E   = 6'd41;
  localparam raddr_t RA_C   = 6'd42;
  localparam raddr_t RA_F   = 6'd43;
  localparam raddr_t RA_DEN = 6'd44;
  localparam raddr_t RA_SN  = 6'd45;
  localparam raddr_t RA_TN  = 6'd46;
  localparam raddr_t RA_N   = 6'd47;
  localparam raddr_t RA_RN  = 6'd50;

  // words loaded before the program runs (zero, points, radius sum)
  localparam int LOAD_LAST = 13;

  // flags: five per point-to-segment check, six for the interior check
  localparam int NUM_FLAGS = 26;
  localparam int PF_WD     = 0;  // w.d <= 0
  localparam int PF_DD     = 1;  // d.d <= w.d
  localparam int PF_WW     = 2;  // w.w <= r2
  localparam int PF_VV     = 3;  // v.v <= r2
  localparam int PF_IN     = 4;  // perpendicular foot within reach
  localparam int PS_FLAGS  = 5;
  localparam int IF_BASE   = 20;
  localparam int IF_DEN    = 20; // den <= 0
  localparam int IF_SN_GE  = 21; // sn >= 0
  localparam int IF_SN_LE  = 22; // sn <= den
  localparam int IF_TN_GE  = 23; // tn >= 0
  localparam int IF_TN_LE  = 24; // tn <= den
  localparam int IF_DIST   = 25; // rn^2 <= r2 * den

  // scalar operations of the shared unit
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_CMP = 2'd3
  } op_t;

  typedef struct packed {
    op_t    op;
    raddr_t dst;  // register, or flag number for a compare
    raddr_t a;
    raddr_t b;
  } instr_t;

  // program segments
  localparam int SEG_W = 3;
  localparam int STEP_W = 7;
  localparam logic [SEG_W-1:0] SEG_PRO = 3'd0;
  localparam logic [SEG_W-1:0] SEG_PS0 = 3'd1;
  localparam logic [SEG_W-1:0] SEG_PS1 = 3'd2;
  localparam logic [SEG_W-1:0] SEG_PS2 = 3'd3;
  localparam logic [SEG_W-1:0] SEG_PS3 = 3'd4;
  localparam logic [SEG_W-1:0] SEG_INT = 3'd5;

  localparam logic [STEP_W-1:0] PRO_LAST = 7'd0;
  localparam logic [STEP_W-1:0] PS_LAST  = 7'd37;
  localparam logic [STEP_W-1:0] INT_LAST = 7'd64;

  function automatic instr_t mk(input op_t op, input raddr_t d, input raddr_t a,
                                input raddr_t b);
    instr_t r;
    r.op  = op;
    r.dst = d;
    r.a   = a;
    r.b   = b;
    return r;
  endfunction

  // three-term dot product over t0/t1
  function automatic instr_t dot_ins(input logic [2:0] k, input raddr_t dst,
                                     input raddr_t u, input raddr_t v);
    instr_t r;
    case (k)
      3'd0:    r = mk(OP_MUL, RA_T0, u, v);
      3'd1:    r = mk(OP_MUL, RA_T1, u + 6'd1, v + 6'd1);
      3'd2:    r = mk(OP_ADD, RA_T0, RA_T0, RA_T1);
      3'd3:    r = mk(OP_MUL, RA_T1, u + 6'd2, v + 6'd2);
      default: r = mk(OP_ADD, dst, RA_T0, RA_T1);
    endcase
    return r;
  endfunction

  // point p against segment s..e, flags from fb
  function automatic instr_t ps_ins(input logic [STEP_W-1:0] st, input raddr_t p,
                                    input raddr_t s, input raddr_t e, input raddr_t fb);
    instr_t r;
    raddr_t k;
    k = raddr_t'(st);
    if (st < 7'd3)       r = mk(OP_SUB, RA_W + k, p + k, s + k);
    else if (st < 7'd6)  r = mk(OP_SUB, RA_D + k - 6'd3, e + k - 6'd3, s + k - 6'd3);
    else if (st < 7'd9)  r = mk(OP_SUB, RA_V + k - 6'd6, p + k - 6'd6, e + k - 6'd6);
    else if (st < 7'd14) r = dot_ins(3'(st - 7'd9), RA_WD, RA_W, RA_D);
    else if (st < 7'd19) r = dot_ins(3'(st - 7'd14), RA_DD, RA_D, RA_D);
    else if (st < 7'd24) r = dot_ins(3'(st - 7'd19), RA_WW, RA_W, RA_W);
    else if (st < 7'd29) r = dot_ins(3'(st - 7'd24), RA_VV, RA_V, RA_V);
    else begin
      case (st)
        7'd29:   r = mk(OP_CMP, fb + 6'(PF_WD), RA_WD, RA_Z);
        7'd30:   r = mk(OP_CMP, fb + 6'(PF_DD), RA_DD, RA_WD);
        7'd31:   r = mk(OP_CMP, fb + 6'(PF_WW), RA_WW, RA_R2);
        7'd32:   r = mk(OP_CMP, fb + 6'(PF_VV), RA_VV, RA_R2);
        7'd33:   r = mk(OP_MUL, RA_T0, RA_WW, RA_DD);
        7'd34:   r = mk(OP_MUL, RA_T1, RA_R2, RA_DD);
        7'd35:   r = mk(OP_MUL, RA_VV, RA_WD, RA_WD);
        7'd36:   r = mk(OP_ADD, RA_T1, RA_T1, RA_VV);
        default: r = mk(OP_CMP, fb + 6'(PF_IN), RA_T0, RA_T1);
      endcase
    end
    return r;
  endfunction

  // interior critical point of the two lines
  function automatic instr_t int_ins(input logic [STEP_W-1:0] st);
    instr_t r;
    raddr_t k;
    k = raddr_t'(st);
    if (st < 7'd3)       r = mk(OP_SUB, RA_D1 + k, RA_Q + k, RA_P + k);
    else if (st < 7'd6)  r = mk(OP_SUB, RA_D2 + k - 6'd3, RA_E2 + k - 6'd3, RA_S2 + k - 6'd3);
    else if (st < 7'd9)  r = mk(OP_SUB, RA_RR + k - 6'd6, RA_P + k - 6'd6, RA_S2 + k - 6'd6);
    else if (st < 7'd14) r = dot_ins(3'(st - 7'd9), RA_A, RA_D1, RA_D1);
    else if (st < 7'd19) r = dot_ins(3'(st - 7'd14), RA_B, RA_D1, RA_D2);
    else if (st < 7'd24) r = dot_ins(3'(st - 7'd19), RA_E, RA_D2, RA_D2);
    else if (st < 7'd29) r = dot_ins(3'(st - 7'd24), RA_C, RA_D1, RA_RR);
    else if (st < 7'd34) r = dot_ins(3'(st - 7'd29), RA_F, RA_D2, RA_RR);
    else if (st >= 7'd52 && st < 7'd57) r = dot_ins(3'(st - 7'd52), RA_RN, RA_RR, RA_N);
    else begin
      case (st)
        7'd34:   r = mk(OP_MUL, RA_T0, RA_A, RA_E);
        7'd35:   r = mk(OP_MUL, RA_T1, RA_B, RA_B);
        7'd36:   r = mk(OP_SUB, RA_DEN, RA_T0, RA_T1);
        7'd37:   r = mk(OP_MUL, RA_T0, RA_B, RA_F);
        7'd38:   r = mk(OP_MUL, RA_T1, RA_C, RA_E);
        7'd39:   r = mk(OP_SUB, RA_SN, RA_T0, RA_T1);
        7'd40:   r = mk(OP_MUL, RA_T0, RA_A, RA_F);
        7'd41:   r = mk(OP_MUL, RA_T1, RA_B, RA_C);
        7'd42:   r = mk(OP_SUB, RA_TN, RA_T0, RA_T1);
        7'd43:   r = mk(OP_MUL, RA_T0, RA_D1 + 6'd1, RA_D2 + 6'd2);
        7'd44:   r = mk(OP_MUL, RA_T1, RA_D1 + 6'd2, RA_D2 + 6'd1);
        7'd45:   r = mk(OP_SUB, RA_N, RA_T0, RA_T1);
        7'd46:   r = mk(OP_MUL, RA_T0, RA_D1 + 6'd2, RA_D2);
        7'd47:   r = mk(OP_MUL, RA_T1, RA_D1, RA_D2 + 6'd2);
        7'd48:   r = mk(OP_SUB, RA_N + 6'd1, RA_T0, RA_T1);
        7'd49:   r = mk(OP_MUL, RA_T0, RA_D1, RA_D2 + 6'd1);
        7'd50:   r = mk(OP_MUL, RA_T1, RA_D1 + 6'd1, RA_D2);
        7'd51:   r = mk(OP_SUB, RA_N + 6'd2, RA_T0, RA_T1);
        7'd57:   r = mk(OP_MUL, RA_T0, RA_RN, RA_RN);
        7'd58:   r = mk(OP_MUL, RA_T1, RA_R2, RA_DEN);
        7'd59:   r = mk(OP_CMP, 6'(IF_DEN), RA_DEN, RA_Z);
        7'd60:   r = mk(OP_CMP, 6'(IF_SN_GE), RA_Z, RA_SN);
        7'd61:   r = mk(OP_CMP, 6'(IF_SN_LE), RA_SN, RA_DEN);
        7'd62:   r = mk(OP_CMP, 6'(IF_TN_GE), RA_Z, RA_TN);
        7'd63:   r = mk(OP_CMP, 6'(IF_TN_LE), RA_TN, RA_DEN);
        default: r = mk(OP_CMP, 6'(IF_DIST), RA_T0, RA_T1);
      endcase
    end
    return r;
  endfunction

  // instruction store
  function automatic instr_t ucode(input logic [SEG_W-1:0] seg, input logic [STEP_W-1:0] st);
    instr_t r;
    case (seg)
      SEG_PRO: r = mk(OP_MUL, RA_R2, RA_RS, RA_RS);
      SEG_PS0: r = ps_ins(st, RA_P, RA_S2, RA_E2, 6'(0 * PS_FLAGS));
      SEG_PS1: r = ps_ins(st, RA_Q, RA_S2, RA_E2, 6'(1 * PS_FLAGS));
      SEG_PS2: r = ps_ins(st, RA_S2, RA_P, RA_Q, 6'(2 * PS_FLAGS));
      SEG_PS3: r = ps_ins(st, RA_E2, RA_P, RA_Q, 6'(3 * PS_FLAGS));
      default: r = int_ins(st);
    endcase
    return r;
  endfunction

  function automatic logic [STEP_W-1:0] seg_last(input logic [SEG_W-1:0] seg);
    logic [STEP_W-1:0] r;
    case (seg)
      SEG_PRO: r = PRO_LAST;
      SEG_INT: r = INT_LAST;
      default: r = PS_LAST;
    endcase
    return r;
  endfunction

endpackage

[design/capsule_overlap_test_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capsule_overlap_test_unit: stored capsule and segment-segment overlap test
// Holds one capsule's endpoints, moves them on update words and answers test
// words with an exact fixed-point closest-points overlap decision.
// ----------------------------------------------------------------------------
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  input    | in_valid, in_stall, operation..      | in
//  result   | out_valid, out_stall, overlap        | out
//  config   | cfg_write, cfg_index, cfg_data       | in
//
//  an update word leaves the sequencer idle; a test word loads 14 words into the
//  register file, then runs 218 scalar operations (93 of them multiplies)
//  each operation reads its operands, then executes; a multiply also steps
//  through na*nb limb products, with na, nb the 32-bit limbs in use, on a
//  32x32 limb multiplier, then writes back through the single write port
//  rst is synchronous and clears control state and the stored capsule
//  a finished result waits in the output register; new words are taken
//  while it waits, the next test holds at its end until the register frees
// ----------------------------------------------------------------------------
module capsule_overlap_test_unit
  import cot_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [INDEX_BITS-1:0]         first_index,
  input  logic [INDEX_BITS-1:0]         second_index,
  input  logic signed [COORD_BITS-1:0]  point_a_x,
  input  logic signed [COORD_BITS-1:0]  point_a_y,
  input  logic signed [COORD_BITS-1:0]  point_a_z,
  input  logic signed [COORD_BITS-1:0]  point_b_x,
  input  logic signed [COORD_BITS-1:0]  point_b_y,
  input  logic signed [COORD_BITS-1:0]  point_b_z,
  input  logic [RADIUS_BITS-1:0]        other_radius,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          overlap
);

  localparam int WIDE = 6 * COORD_BITS + 60;
  localparam int NCH  = (WIDE + 31) / 32;
  localparam int PADW = NCH * 32;
  localparam int IW   = $clog2(NCH);
  localparam int CNTW = $clog2(NCH + 1);
  localparam int SW   = IW + 1;
  localparam int FAW  = $clog2(NUM_FLAGS);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_LOAD  = 8'b0000_0010,
    ST_READ  = 8'b0000_0100,
    ST_EXEC  = 8'b0000_1000,
    ST_MUL   = 8'b0001_0000,
    ST_DRAIN = 8'b0010_0000,
    ST_MWR   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [RADIUS_BITS-1:0]       own_radius;
  logic [INDEX_BITS-1:0]        head_bone_index;
  logic [INDEX_BITS-1:0]        tail_bone_index;
  logic signed [COORD_BITS-1:0] offset [3];

  // stored capsule and latched test word
  logic signed [COORD_BITS-1:0] start_point [3];
  logic signed [COORD_BITS-1:0] end_point [3];
  logic signed [COORD_BITS-1:0] pa [3];
  logic signed [COORD_BITS-1:0] pb [3];
  logic signed [COORD_BITS-1:0] in_a [3];
  logic signed [COORD_BITS-1:0] in_b [3];
  logic signed [COORD_BITS-1:0] sat_a [3];
  logic signed [COORD_BITS-1:0] sat_b [3];
  logic [RADIUS_BITS:0]         rsum;

  // sequencer
  logic [3:0]        load_cnt;
  logic [SEG_W-1:0]  seg;
  logic [STEP_W-1:0] step;
  instr_t            ins;
  logic              last_ins;

  // register file
  logic [WIDE-1:0]  rf [RF_DEPTH];
  logic [WIDE-1:0]  rd_a;
  logic [WIDE-1:0]  rd_b;
  logic             wr_en;
  raddr_t           wr_addr;
  logic [WIDE-1:0]  wr_data;
  logic [WIDE-1:0]  load_word;
  logic [WIDE-1:0]  alu_res;
  logic             le_flag;
  logic [NUM_FLAGS-1:0] flags;

  // multiplier
  logic [WIDE-1:0] abs_a;
  logic [WIDE-1:0] abs_b;
  logic [PADW-1:0] pad_a;
  logic [PADW-1:0] pad_b;
  logic [CNTW-1:0] na_c;
  logic [CNTW-1:0] nb_c;
  logic [PADW-1:0] mag_a;
  logic [PADW-1:0] mag_b;
  logic [CNTW-1:0] na;
  logic [CNTW-1:0] nb;
  logic [IW-1:0]   ci;
  logic [IW-1:0]   cj;
  logic            msign;
  logic [63:0]     pp;
  logic [SW-1:0]   pp_sh;
  logic            pp_valid;
  logic [PADW-1:0] acc;
  logic [WIDE-1:0] mul_res;

  logic in_acc;
  logic hit;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign in_a[0] = point_a_x;
  assign in_a[1] = point_a_y;
  assign in_a[2] = point_a_z;
  assign in_b[0] = point_b_x;
  assign in_b[1] = point_b_y;
  assign in_b[2] = point_b_z;

  // saturating bone point plus offset
  always_comb begin
    logic [COORD_BITS:0] sa;
    logic [COORD_BITS:0] sb;
    for (int k = 0; k < 3; k++) begin
      sa = {in_a[k][COORD_BITS-1], in_a[k]} + {offset[k][COORD_BITS-1], offset[k]};
      sb = {in_b[k][COORD_BITS-1], in_b[k]} + {offset[k][COORD_BITS-1], offset[k]};
      if (sa[COORD_BITS] != sa[COORD_BITS-1])
        sat_a[k] = {sa[COORD_BITS], {(COORD_BITS-1){~sa[COORD_BITS]}}};
      else
        sat_a[k] = sa[COORD_BITS-1:0];
      if (sb[COORD_BITS] != sb[COORD_BITS-1])
        sat_b[k] = {sb[COORD_BITS], {(COORD_BITS-1){~sb[COORD_BITS]}}};
      else
        sat_b[k] = sb[COORD_BITS-1:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      own_radius      <= '0;
      head_bone_index <= '0;
      tail_bone_index <= '0;
      for (int k = 0; k < 3; k++) offset[k] <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_OWN_RADIUS: own_radius      <= cfg_data[RADIUS_BITS-1:0];
        CFG_HEAD_INDEX: head_bone_index <= cfg_data[INDEX_BITS-1:0];
        CFG_TAIL_INDEX: tail_bone_index <= cfg_data[INDEX_BITS-1:0];
        CFG_OFFSET_X:   offset[0]       <= cfg_data[COORD_BITS-1:0];
        CFG_OFFSET_Y:   offset[1]       <= cfg_data[COORD_BITS-1:0];
        CFG_OFFSET_Z:   offset[2]       <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stored endpoints follow update words
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        start_point[k] <= '0;
        end_point[k]   <= '0;
      end
    end else if (in_acc && operation == OPER_UPDATE) begin
      if (first_index == head_bone_index)
        for (int k = 0; k < 3; k++) start_point[k] <= sat_a[k];
      if (second_index == tail_bone_index)
        for (int k = 0; k < 3; k++) end_point[k] <= sat_b[k];
    end
  end

  // latch the test word
  always_ff @(posedge clk) begin
    if (in_acc && operation == OPER_TEST) begin
      for (int k = 0; k < 3; k++) begin
        pa[k] <= in_a[k];
        pb[k] <= in_b[k];
      end
      rsum <= {1'b0, own_radius} + {1'b0, other_radius};
    end
  end

  // current instruction
  assign ins      = ucode(seg, step);
  assign last_ins = (seg == SEG_INT) && (step == INT_LAST);

  // words loaded before the program
  always_comb begin
    logic signed [COORD_BITS-1:0] c;
    c = '0;
    case (load_cnt)
      4'd1:  c = start_point[0];
      4'd2:  c = start_point[1];
      4'd3:  c = start_point[2];
      4'd4:  c = end_point[0];
      4'd5:  c = end_point[1];
      4'd6:  c = end_point[2];
      4'd7:  c = pa[0];
      4'd8:  c = pa[1];
      4'd9:  c = pa[2];
      4'd10: c = pb[0];
      4'd11: c = pb[1];
      4'd12: c = pb[2];
      default: c = '0;
    endcase
    if (load_cnt == 4'(LOAD_LAST))
      load_word = {{(WIDE-RADIUS_BITS-1){1'b0}}, rsum};
    else
      load_word = {{(WIDE-COORD_BITS){c[COORD_BITS-1]}}, c};
  end

  // add, subtract and compare
  always_comb begin
    case (ins.op)
      OP_ADD:  alu_res = rd_a + rd_b;
      default: alu_res = rd_a - rd_b;
    endcase
    le_flag = alu_res[WIDE-1] | ~|alu_res;
  end

  assign mul_res = msign ? (WIDE'(0) - acc[WIDE-1:0]) : acc[WIDE-1:0];

  // register file write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = raddr_t'(load_cnt);
    wr_data = load_word;
    unique case (state)
      ST_LOAD: wr_en = 1'b1;
      ST_EXEC: begin
        wr_en   = (ins.op == OP_ADD) || (ins.op == OP_SUB);
        wr_addr = ins.dst;
        wr_data = alu_res;
      end
      ST_MWR: begin
        wr_en   = 1'b1;
        wr_addr = ins.dst;
        wr_data = mul_res;
      end
      default: ;
    endcase
  end

  // register file storage with registered reads
  always_ff @(posedge clk) begin
    if (wr_en) rf[wr_addr] <= wr_data;
    rd_a <= rf[ins.a];
    rd_b <= rf[ins.b];
  end

  // operand magnitudes and limb counts
  always_comb begin
    abs_a = rd_a[WIDE-1] ? (WIDE'(0) - rd_a) : rd_a;
    abs_b = rd_b[WIDE-1] ? (WIDE'(0) - rd_b) : rd_b;
    pad_a = PADW'(abs_a);
    pad_b = PADW'(abs_b);
    na_c  = CNTW'(1);
    nb_c  = CNTW'(1);
    for (int k = 0; k < NCH; k++) begin
      if (|pad_a[k*32 +: 32]) na_c = CNTW'(k + 1);
      if (|pad_b[k*32 +: 32]) nb_c = CNTW'(k + 1);
    end
  end

  // limb products and accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid <= 1'b0;
    end else begin
      pp_valid <= (state == ST_MUL);
    end
    if (state == ST_MUL) begin
      pp    <= 64'(mag_a[{ci, 5'b0} +: 32]) * 64'(mag_b[{cj, 5'b0} +: 32]);
      pp_sh <= SW'(ci) + SW'(cj);
    end
    if (state == ST_EXEC) begin
      acc   <= '0;
      mag_a <= pad_a;
      mag_b <= pad_b;
      na    <= na_c;
      nb    <= nb_c;
      msign <= rd_a[WIDE-1] ^ rd_b[WIDE-1];
    end else if (pp_valid) begin
      acc <= acc + (PADW'(pp) << {pp_sh, 5'b0});
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      load_cnt <= '0;
      seg      <= SEG_PRO;
      step     <= '0;
      ci       <= '0;
      cj       <= '0;
      flags    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc && operation == OPER_TEST) begin
            state    <= ST_LOAD;
            load_cnt <= '0;
            seg      <= SEG_PRO;
            step     <= '0;
            flags    <= '0;
          end
        end
        ST_LOAD: begin
          load_cnt <= load_cnt + 4'd1;
          if (load_cnt == 4'(LOAD_LAST)) state <= ST_READ;
        end
        ST_READ: state <= ST_EXEC;
        ST_EXEC, ST_MWR: begin
          if (state == ST_EXEC && ins.op == OP_MUL) begin
            state <= ST_MUL;
            ci    <= '0;
            cj    <= '0;
          end else begin
            if (state == ST_EXEC && ins.op == OP_CMP)
              flags[ins.dst[FAW-1:0]] <= le_flag;
            if (last_ins) begin
              state <= ST_FIN;
            end else begin
              state <= ST_READ;
              if (step == seg_last(seg)) begin
                seg  <= seg + 3'd1;
                step <= '0;
              end else begin
                step <= step + 7'd1;
              end
            end
          end
        end
        ST_MUL: begin
          if ((CNTW'(cj) + CNTW'(1)) == nb) begin
            cj <= '0;
            if ((CNTW'(ci) + CNTW'(1)) == na) state <= ST_DRAIN;
            else ci <= ci + IW'(1);
          end else begin
            cj <= cj + IW'(1);
          end
        end
        ST_DRAIN: state <= ST_MWR;
        ST_FIN: begin
          if (!out_valid || !out_stall) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // overlap decision from the flags
  always_comb begin
    hit = 1'b0;
    for (int p = 0; p < 4; p++) begin
      if (flags[p*PS_FLAGS + PF_WD])      hit = hit | flags[p*PS_FLAGS + PF_WW];
      else if (flags[p*PS_FLAGS + PF_DD]) hit = hit | flags[p*PS_FLAGS + PF_VV];
      else                                hit = hit | flags[p*PS_FLAGS + PF_IN];
    end
    hit = hit | (!flags[IF_DEN] && flags[IF_SN_GE] && flags[IF_SN_LE]
                 && flags[IF_TN_GE] && flags[IF_TN_LE] && flags[IF_DIST]);
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    if (state == ST_FIN && (!out_valid || !out_stall)) overlap <= hit;
  end

  // checks
  a_onehot_state: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("result word raised outside the final state");

  a_update_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_acc && operation == OPER_UPDATE) |=> (state == ST_IDLE))
    else $error("update word started the sequencer");

  a_limbs_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> ((CNTW'(ci) < na) && (CNTW'(cj) < nb)))
    else $error("multiplier limb index out of range");

  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_valid && out_stall) |=> (state == ST_FIN))
    else $error("final state left while the result register was full");

endmodule
